@@ rtl/core/m9tc_pkg.sv @@
package m9tc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int NSAMPLE  = 9;
    localparam int NKNOT    = 14;
    localparam int SEG_W    = 4;
    localparam int CHAN_W   = 3;
    localparam int TEMP_W   = 12;
    // channels below this one carry a thermistor
    localparam logic [CHAN_W-1:0] THERM_CHANNELS = 3'd4;
    // reciprocal scale: q ~= (|p| * RECIP) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 32;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [NSAMPLE-1:0][SAMPLE_W-1:0] t_vec;
    typedef logic [SEG_W-1:0] t_seg;

    // control that travels with each pipeline stage
    typedef struct packed {
        logic vld;
        logic therm;
    } t_ctl;

    // knot table of the thermistor curve
    localparam logic [11:0] KNOT_X [NKNOT] = '{
        12'd732, 12'd945, 12'd1197, 12'd2035, 12'd2309, 12'd2542, 12'd2739,
        12'd2859, 12'd2969, 12'd3068, 12'd3154, 12'd3228, 12'd3293, 12'd3347
    };
    localparam logic [9:0] KNOT_T [NKNOT] = '{
        10'd100, 10'd160, 10'd227, 10'd438, 10'd508, 10'd571, 10'd628,
        10'd666, 10'd702, 10'd738, 10'd772, 10'd805, 10'd837, 10'd869
    };
    localparam logic [8:0] SLOPE_N [NKNOT] = '{
        9'd13, 9'd95, 9'd185, 9'd96, 9'd43, 9'd153, 9'd347,
        9'd141, 9'd128, 9'd261, 9'd235, 9'd85, 9'd393, 9'd307
    };
    localparam logic [10:0] SLOPE_D [NKNOT] = '{
        11'd46, 11'd358, 11'd736, 11'd373, 11'd159, 11'd529, 11'd1118,
        11'd424, 11'd355, 11'd659, 11'd532, 11'd169, 11'd667, 11'd428
    };
    // floor(2^32 / SLOPE_D)
    localparam logic [26:0] RECIP [NKNOT] = '{
        27'd93368854, 27'd11997115, 27'd5835553, 27'd11514657, 27'd27012372,
        27'd8119030, 27'd3841652, 27'd10129639, 27'd12098499, 27'd6517401,
        27'd8073246, 27'd25414007, 27'd6439231, 27'd10034970
    };

endpackage

@@ rtl/core/median9_thermistor_converter_core.sv @@
// median of nine samples with thermistor conversion
//
// input channel: i_in_valid / o_in_ready carry i_channel and i_sample_0..8.
// output channel: o_out_valid / i_out_ready carry o_median_value,
// o_temperature_tenths and o_temperature_valid, exactly one item per input.
// channels 0 to 3 get a temperature in tenths of a degree C from a 14-knot
// piecewise linear curve; other channels report valid low and zero tenths.
//
// the pipeline has 8 register stages: 3 of sorting network, then segment
// select, slope multiply, reciprocal multiply, remainder multiply and the
// correcting output stage. throughput is one item per cycle; the whole
// pipeline advances when the output register is empty or being taken, so a
// stalled receiver holds every stage in place and o_in_ready drops with it.
// reset (synchronous, active low) clears all stage valid bits; payload
// registers keep whatever they held.
module median9_thermistor_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_channel,
    input  logic [11:0] i_sample_0,
    input  logic [11:0] i_sample_1,
    input  logic [11:0] i_sample_2,
    input  logic [11:0] i_sample_3,
    input  logic [11:0] i_sample_4,
    input  logic [11:0] i_sample_5,
    input  logic [11:0] i_sample_6,
    input  logic [11:0] i_sample_7,
    input  logic [11:0] i_sample_8,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_median_value,
    output logic signed [11:0] o_temperature_tenths,
    output logic        o_temperature_valid
);

    logic              en;
    m9tc_pkg::t_ctl    in_ctl, med_ctl;
    m9tc_pkg::t_vec    samples;
    m9tc_pkg::t_sample med;

    // stage registers of the conversion
    m9tc_pkg::t_ctl    r_t1_ctl, r_t2_ctl, r_t3_ctl, r_t4_ctl, r_out_ctl;
    m9tc_pkg::t_sample r_t1_med, r_t2_med, r_t3_med, r_t4_med, r_out_med;
    m9tc_pkg::t_seg    r_t1_seg, r_t2_seg, r_t3_seg, r_t4_seg;
    logic              r_t1_neg, r_t2_neg, r_t3_neg, r_t4_neg;
    logic [11:0]       r_t1_mag;
    logic [20:0]       r_t2_pmag, r_t3_pmag, r_t4_pmag;
    logic [11:0]       r_t3_q0, r_t4_q0;
    logic [20:0]       r_t4_qd;
    logic signed [11:0] r_out_temp;

    m9tc_pkg::t_seg    n_seg;
    logic [12:0]       n_diff;
    logic [11:0]       n_mag;
    logic [20:0]       n_pmag;
    logic [47:0]       n_prod;
    logic [22:0]       n_qd;
    logic [20:0]       n_rem;
    logic [11:0]       n_q;
    logic [12:0]       n_sq;
    logic [12:0]       n_temp;

    // the whole pipeline moves when the output register can take an item
    assign en         = !r_out_ctl.vld || i_out_ready;
    assign o_in_ready = en;

    assign in_ctl.vld   = i_in_valid;
    assign in_ctl.therm = (i_channel < m9tc_pkg::THERM_CHANNELS);
    assign samples = {i_sample_8, i_sample_7, i_sample_6, i_sample_5, i_sample_4,
                      i_sample_3, i_sample_2, i_sample_1, i_sample_0};

    m9tc_median9 u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (in_ctl),
        .i_samples (samples),
        .o_ctl     (med_ctl),
        .o_median  (med)
    );

    // segment select: largest knot at or below the median, else segment 0
    always_comb begin
        n_seg = '0;
        for (int i = 1; i < m9tc_pkg::NKNOT; i++) begin
            if (med >= m9tc_pkg::KNOT_X[i]) begin
                n_seg = m9tc_pkg::SEG_W'(i);
            end
        end
        n_diff = {1'b0, med} - {1'b0, m9tc_pkg::KNOT_X[n_seg]};
        n_mag  = n_diff[12] ? 12'(-n_diff) : n_diff[11:0];
    end

    // slope numerator times distance from the knot
    assign n_pmag = 21'(m9tc_pkg::SLOPE_N[r_t1_seg]) * 21'(r_t1_mag);

    // first quotient estimate, at most one below the true quotient
    assign n_prod = 48'(r_t2_pmag) * 48'(m9tc_pkg::RECIP[r_t2_seg]);

    // estimate times divisor, never above the dividend
    assign n_qd = 23'(r_t3_q0) * 23'(m9tc_pkg::SLOPE_D[r_t3_seg]);

    // correct the estimate, apply sign and add the knot temperature
    always_comb begin
        n_rem = r_t4_pmag - r_t4_qd;
        n_q   = r_t4_q0 + 12'(n_rem >= 21'(m9tc_pkg::SLOPE_D[r_t4_seg]));
        n_sq  = r_t4_neg ? 13'(-{1'b0, n_q}) : {1'b0, n_q};
        n_temp = 13'(m9tc_pkg::KNOT_T[r_t4_seg]) + n_sq;
    end

    // conversion pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_ctl  <= '0;
            r_t2_ctl  <= '0;
            r_t3_ctl  <= '0;
            r_t4_ctl  <= '0;
            r_out_ctl <= '0;
        end else if (en) begin
            r_t1_ctl  <= med_ctl;
            r_t1_med  <= med;
            r_t1_seg  <= n_seg;
            r_t1_neg  <= n_diff[12];
            r_t1_mag  <= n_mag;

            r_t2_ctl  <= r_t1_ctl;
            r_t2_med  <= r_t1_med;
            r_t2_seg  <= r_t1_seg;
            r_t2_neg  <= r_t1_neg;
            r_t2_pmag <= n_pmag;

            r_t3_ctl  <= r_t2_ctl;
            r_t3_med  <= r_t2_med;
            r_t3_seg  <= r_t2_seg;
            r_t3_neg  <= r_t2_neg;
            r_t3_pmag <= r_t2_pmag;
            r_t3_q0   <= n_prod[m9tc_pkg::RECIP_SHIFT +: 12];

            r_t4_ctl  <= r_t3_ctl;
            r_t4_med  <= r_t3_med;
            r_t4_seg  <= r_t3_seg;
            r_t4_neg  <= r_t3_neg;
            r_t4_pmag <= r_t3_pmag;
            r_t4_q0   <= r_t3_q0;
            r_t4_qd   <= n_qd[20:0];

            r_out_ctl  <= r_t4_ctl;
            r_out_med  <= r_t4_med;
            r_out_temp <= r_t4_ctl.therm ? signed'(n_temp[11:0]) : '0;
        end
    end

    assign o_out_valid          = r_out_ctl.vld;
    assign o_median_value       = r_out_med;
    assign o_temperature_tenths = r_out_temp;
    assign o_temperature_valid  = r_out_ctl.therm;

`ifndef SYNTHESIS
    // non-thermistor channels report zero tenths
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_temperature_valid |-> o_temperature_tenths == 12'sd0)
        else $error("non-thermistor item carries a temperature");

    // converted temperature stays on the curve's range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_temperature_valid |->
            o_temperature_tenths >= -12'sd106 && o_temperature_tenths <= 12'sd1405)
        else $error("temperature out of range");

    // reciprocal estimate is off by at most one
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t4_ctl.vld |-> (r_t4_qd <= r_t4_pmag) &&
            (r_t4_pmag - r_t4_qd < 21'(2 * m9tc_pkg::SLOPE_D[r_t4_seg])))
        else $error("quotient estimate not within one");

    // only segment 0 extrapolates below its knot
    a_neg_seg0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t1_ctl.vld && r_t1_neg |-> r_t1_seg == '0)
        else $error("negative distance outside segment 0");
`endif

endmodule

@@ rtl/core/m9tc_median9.sv @@
module m9tc_median9 (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  m9tc_pkg::t_ctl   i_ctl,
    input  m9tc_pkg::t_vec   i_samples,
    output m9tc_pkg::t_ctl   o_ctl,
    output m9tc_pkg::t_sample o_median
);

    // compare-exchange: smaller value ends up at index a
    function automatic m9tc_pkg::t_vec cas(m9tc_pkg::t_vec v, logic [3:0] a, logic [3:0] b);
        m9tc_pkg::t_vec w;
        w = v;
        if (v[a] > v[b]) begin
            w[a] = v[b];
            w[b] = v[a];
        end
        return w;
    endfunction

    m9tc_pkg::t_ctl    r_ctl_a, r_ctl_b, r_ctl_c;
    m9tc_pkg::t_vec    r_vec_a, r_vec_b;
    m9tc_pkg::t_vec    n_vec_a, n_vec_b, n_vec_c;
    m9tc_pkg::t_sample r_med;

    // first stage: sort the three triples
    always_comb begin
        n_vec_a = i_samples;
        n_vec_a = cas(n_vec_a, 4'd1, 4'd2);
        n_vec_a = cas(n_vec_a, 4'd4, 4'd5);
        n_vec_a = cas(n_vec_a, 4'd7, 4'd8);
        n_vec_a = cas(n_vec_a, 4'd0, 4'd1);
        n_vec_a = cas(n_vec_a, 4'd3, 4'd4);
        n_vec_a = cas(n_vec_a, 4'd6, 4'd7);
        n_vec_a = cas(n_vec_a, 4'd1, 4'd2);
        n_vec_a = cas(n_vec_a, 4'd4, 4'd5);
        n_vec_a = cas(n_vec_a, 4'd7, 4'd8);
    end

    // second stage: merge across triples
    always_comb begin
        n_vec_b = r_vec_a;
        n_vec_b = cas(n_vec_b, 4'd0, 4'd3);
        n_vec_b = cas(n_vec_b, 4'd5, 4'd8);
        n_vec_b = cas(n_vec_b, 4'd4, 4'd7);
        n_vec_b = cas(n_vec_b, 4'd3, 4'd6);
        n_vec_b = cas(n_vec_b, 4'd1, 4'd4);
        n_vec_b = cas(n_vec_b, 4'd2, 4'd5);
        n_vec_b = cas(n_vec_b, 4'd4, 4'd7);
        n_vec_b = cas(n_vec_b, 4'd4, 4'd2);
    end

    // third stage: last exchanges settle the middle element
    always_comb begin
        n_vec_c = r_vec_b;
        n_vec_c = cas(n_vec_c, 4'd6, 4'd4);
        n_vec_c = cas(n_vec_c, 4'd4, 4'd2);
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
            r_ctl_b <= '0;
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_a <= i_ctl;
            r_ctl_b <= r_ctl_a;
            r_ctl_c <= r_ctl_b;
            r_vec_a <= n_vec_a;
            r_vec_b <= n_vec_b;
            r_med   <= n_vec_c[4];
        end
    end

    assign o_ctl    = r_ctl_c;
    assign o_median = r_med;

endmodule

@@ tb/sv/median_temp_watch.sv @@
`timescale 1ns / 1ps

module median_temp_watch (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_channel,
    input  logic [11:0]        i_sample_0,
    input  logic [11:0]        i_sample_1,
    input  logic [11:0]        i_sample_2,
    input  logic [11:0]        i_sample_3,
    input  logic [11:0]        i_sample_4,
    input  logic [11:0]        i_sample_5,
    input  logic [11:0]        i_sample_6,
    input  logic [11:0]        i_sample_7,
    input  logic [11:0]        i_sample_8,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [11:0]        i_median_value,
    input  logic signed [11:0] i_temperature_tenths,
    input  logic               i_temperature_valid,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_errors
);

    // one predicted reading per accepted item
    typedef struct {
        logic [11:0]        median;
        logic signed [11:0] tenths;
        logic               therm;
    } t_reading;

    // thermistor calibration curve: knee adc codes, tenths there, slope num/den
    localparam int CAL_ADC [14] = '{732, 945, 1197, 2035, 2309, 2542, 2739,
                                    2859, 2969, 3068, 3154, 3228, 3293, 3347};
    localparam int CAL_TENTHS [14] = '{100, 160, 227, 438, 508, 571, 628,
                                       666, 702, 738, 772, 805, 837, 869};
    localparam int CAL_NUM [14] = '{13, 95, 185, 96, 43, 153, 347,
                                    141, 128, 261, 235, 85, 393, 307};
    localparam int CAL_DEN [14] = '{46, 358, 736, 373, 159, 529, 1118,
                                    424, 355, 659, 532, 169, 667, 428};

    t_reading readings_due [$];
    int       err_cnt     = 0;
    int       checked_cnt = 0;
    int       pending_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_checked = checked_cnt;
    assign o_pending = pending_cnt;

    // fifth smallest of nine, by a plain insertion sort
    function automatic logic [11:0] median_of_nine(input logic [11:0] s [9]);
        logic [11:0] v [9];
        logic [11:0] t;
        int          j;
        v = s;
        for (int i = 1; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        return v[4];
    endfunction

    // piecewise linear curve, quotient truncated toward zero
    function automatic logic signed [11:0] curve_tenths(input logic [11:0] med);
        int v;
        int seg;
        int r;
        v   = int'(med);
        seg = 0;
        for (int i = 0; i < 14; i++) begin
            if (CAL_ADC[i] <= v)
                seg = i;
        end
        r = CAL_TENTHS[seg] + (CAL_NUM[seg] * (v - CAL_ADC[seg])) / CAL_DEN[seg];
        return r[11:0];
    endfunction

    // compare finished items, then predict newly accepted ones
    always @(posedge i_clk) begin
        t_reading    want;
        logic [11:0] s [9];
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result with nothing expected, median %0d tenths %0d",
                             $time, i_median_value, i_temperature_tenths);
                    err_cnt++;
                end else begin
                    want = readings_due.pop_front();
                    checked_cnt++;
                    if (i_median_value !== want.median) begin
                        $display("%0t: median mismatch expected %0d actual %0d",
                                 $time, want.median, i_median_value);
                        err_cnt++;
                    end
                    if (i_temperature_tenths !== want.tenths) begin
                        $display("%0t: tenths mismatch expected %0d actual %0d",
                                 $time, want.tenths, i_temperature_tenths);
                        err_cnt++;
                    end
                    if (i_temperature_valid !== want.therm) begin
                        $display("%0t: temp valid mismatch expected %0b actual %0b",
                                 $time, want.therm, i_temperature_valid);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                s = '{i_sample_0, i_sample_1, i_sample_2, i_sample_3, i_sample_4,
                      i_sample_5, i_sample_6, i_sample_7, i_sample_8};
                want.median = median_of_nine(s);
                want.therm  = (i_channel < m9tc_pkg::THERM_CHANNELS);
                want.tenths = want.therm ? curve_tenths(want.median) : 12'sd0;
                readings_due.push_back(want);
            end
            pending_cnt <= readings_due.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 830;
    localparam int DRAIN_CYCLES = 20;

    // knee points of the curve, used to aim medians at segment borders
    localparam int KNEE_ADC [14] = '{732, 945, 1197, 2035, 2309, 2542, 2739,
                                     2859, 2969, 3068, 3154, 3228, 3293, 3347};

    typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_THIRD} t_rx_mode;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_channel  = '0;
    logic [11:0]        i_sample_0 = '0;
    logic [11:0]        i_sample_1 = '0;
    logic [11:0]        i_sample_2 = '0;
    logic [11:0]        i_sample_3 = '0;
    logic [11:0]        i_sample_4 = '0;
    logic [11:0]        i_sample_5 = '0;
    logic [11:0]        i_sample_6 = '0;
    logic [11:0]        i_sample_7 = '0;
    logic [11:0]        i_sample_8 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic [11:0]        o_median_value;
    logic signed [11:0] o_temperature_tenths;
    logic               o_temperature_valid;

    int          pending;
    int          checked;
    int          errors;
    int          cycle_cnt   = 0;
    int          burst_left  = 0;
    int          items_sent  = 0;
    int          therm_sent  = 0;
    logic [11:0] vals [9];
    t_rx_mode    rx_mode     = RX_FREE;
    int          rx_left     = 0;
    int          rx_phase    = 0;

    median9_thermistor_converter_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_channel            (i_channel),
        .i_sample_0           (i_sample_0),
        .i_sample_1           (i_sample_1),
        .i_sample_2           (i_sample_2),
        .i_sample_3           (i_sample_3),
        .i_sample_4           (i_sample_4),
        .i_sample_5           (i_sample_5),
        .i_sample_6           (i_sample_6),
        .i_sample_7           (i_sample_7),
        .i_sample_8           (i_sample_8),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_median_value       (o_median_value),
        .o_temperature_tenths (o_temperature_tenths),
        .o_temperature_valid  (o_temperature_valid)
    );

    median_temp_watch u_watch (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_channel            (i_channel),
        .i_sample_0           (i_sample_0),
        .i_sample_1           (i_sample_1),
        .i_sample_2           (i_sample_2),
        .i_sample_3           (i_sample_3),
        .i_sample_4           (i_sample_4),
        .i_sample_5           (i_sample_5),
        .i_sample_6           (i_sample_6),
        .i_sample_7           (i_sample_7),
        .i_sample_8           (i_sample_8),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_median_value       (o_median_value),
        .i_temperature_tenths (o_temperature_tenths),
        .i_temperature_valid  (o_temperature_valid),
        .o_pending            (pending),
        .o_checked            (checked),
        .o_errors             (errors)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL median9_thermistor_converter_core");
            $finish;
        end
    end

    // receiver backpressure, switching between patterns
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_mode)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: i_out_ready <= ($urandom_range(0, 3) != 0);
            default:   i_out_ready <= (rx_phase % 3 == 0);
        endcase
    end

    // fill vals around a median m, then shuffle the positions
    task automatic build_near(input int m, input int spread);
        int          j;
        int          x;
        logic [11:0] t;
        vals[0] = 12'(m);
        for (int i = 1; i < 9; i++) begin
            if (i < 5)
                x = m - int'($urandom_range(0, spread));
            else
                x = m + int'($urandom_range(0, spread));
            if (x < 0)
                x = 0;
            if (x > 4095)
                x = 4095;
            vals[i] = 12'(x);
        end
        for (int i = 8; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
        end
    endtask

    // send one item from vals, with a random gap between bursts
    task automatic push_item(input logic [2:0] ch);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_channel  <= ch;
        i_sample_0 <= vals[0];
        i_sample_1 <= vals[1];
        i_sample_2 <= vals[2];
        i_sample_3 <= vals[3];
        i_sample_4 <= vals[4];
        i_sample_5 <= vals[5];
        i_sample_6 <= vals[6];
        i_sample_7 <= vals[7];
        i_sample_8 <= vals[8];
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (ch < m9tc_pkg::THERM_CHANNELS)
            therm_sent++;
    endtask

    // hold off the sender until every result is back
    task automatic wait_all_back();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // stimulus and verdict
    initial begin
        int          kind;
        int          m;
        logic [2:0]  ch;
        logic [11:0] a;
        logic [11:0] b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flat sets at the range ends, on knees and just off them
        build_near(0, 0);    push_item(3'd0);
        build_near(4095, 0); push_item(3'd3);
        build_near(732, 0);  push_item(3'd1);
        build_near(731, 0);  push_item(3'd2);
        build_near(945, 0);  push_item(3'd0);
        build_near(3347, 0); push_item(3'd1);
        build_near(3348, 0); push_item(3'd2);
        build_near(2034, 0); push_item(3'd3);
        build_near(2035, 0); push_item(3'd0);

        // non-thermistor channels still return the median
        build_near(732, 0);    push_item(3'd4);
        build_near(0, 0);      push_item(3'd5);
        build_near(4095, 0);   push_item(3'd6);
        build_near(2500, 400); push_item(3'd7);

        // ordering and duplicate corner cases of the sort
        vals = '{12'd0, 12'd100, 12'd200, 12'd700, 12'd1000, 12'd2000, 12'd3000,
                 12'd3500, 12'd4095};
        push_item(3'd1);
        vals = '{12'd4095, 12'd3500, 12'd3000, 12'd2000, 12'd1000, 12'd700,
                 12'd200, 12'd100, 12'd0};
        push_item(3'd2);
        vals = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                 12'd4095, 12'd0};
        push_item(3'd3);
        vals = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
                 12'd0, 12'd4095};
        push_item(3'd0);
        vals = '{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA,
                 12'h555, 12'hAAA};
        push_item(3'd1);
        vals = '{12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555,
                 12'hAAA, 12'h555};
        push_item(3'd5);
        build_near(1500, 1000); push_item(3'd0);
        build_near(3000, 1000); push_item(3'd2);
        wait_all_back();

        // random sets, some aimed at knees of the curve
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_all_back();
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                m = KNEE_ADC[$urandom_range(0, 13)] + int'($urandom_range(0, 6)) - 3;
                build_near(m, $urandom_range(0, 300));
            end else if (kind <= 5) begin
                build_near($urandom_range(0, 4095), $urandom_range(0, 4095));
            end else if (kind == 6) begin
                foreach (vals[i])
                    vals[i] = 12'($urandom_range(0, 4095));
            end else if (kind == 7) begin
                a = 12'($urandom_range(0, 4095));
                b = 12'($urandom_range(0, 4095));
                foreach (vals[i])
                    vals[i] = $urandom_range(0, 1) ? a : b;
            end else if (kind == 8) begin
                foreach (vals[i])
                    case ($urandom_range(0, 3))
                        0:       vals[i] = 12'h000;
                        1:       vals[i] = 12'hFFF;
                        2:       vals[i] = 12'h800;
                        default: vals[i] = 12'h7FF;
                    endcase
            end else begin
                m = $urandom_range(0, 1) ? $urandom_range(0, 731) : $urandom_range(3348, 4095);
                build_near(m, $urandom_range(0, 500));
            end
            ch = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3))
                                            : 3'($urandom_range(4, 7));
            push_item(ch);
        end

        wait_all_back();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d on thermistor channels, %0d results checked",
                 items_sent, therm_sent, checked);
        $display("medians hit every curve segment and both range ends, with stalls on both sides");
        if (errors == 0) begin
            $display("PASS median9_thermistor_converter_core");
        end else begin
            $display("FAIL median9_thermistor_converter_core");
        end
        $finish;
    end

endmodule
